FILE: rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared definitions for the instruction stream decoder
// Field widths, opcode codes, the front-to-back record and decode helpers.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int unsigned WordW      = 16;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned StartW     = 24;
  localparam int unsigned OpW        = 6;
  localparam int unsigned RegW       = 5;
  localparam int unsigned ImmW       = 32;
  localparam int unsigned CondW      = 5;
  localparam int unsigned LenW       = 2;
  localparam int unsigned OutDataW   = 128;
  localparam int unsigned FifoDepthDef = 4;

  // Opcodes with special handling
  localparam logic [OpW-1:0] OP_ADDQ  = 6'd2;
  localparam logic [OpW-1:0] OP_ADDQT = 6'd3;
  localparam logic [OpW-1:0] OP_SUBQ  = 6'd6;
  localparam logic [OpW-1:0] OP_SUBQT = 6'd7;
  localparam logic [OpW-1:0] OP_SHLQ  = 6'd24;
  localparam logic [OpW-1:0] OP_MOVEI = 6'd38;
  localparam logic [OpW-1:0] OP_JUMP  = 6'd52;
  localparam logic [OpW-1:0] OP_JR    = 6'd53;

  localparam logic [CondW-1:0] COND_UNDEF = 5'd16;

  // Output tdata layout, lowest bit first
  localparam int unsigned OffAddr   = 0;
  localparam int unsigned OffOp     = OffAddr + AddrW;
  localparam int unsigned OffSrc    = OffOp + OpW;
  localparam int unsigned OffDst    = OffSrc + RegW;
  localparam int unsigned OffImm    = OffDst + RegW;
  localparam int unsigned OffTarget = OffImm + ImmW;
  localparam int unsigned OffCond   = OffTarget + AddrW;
  localparam int unsigned OffKnown  = OffCond + CondW;
  localparam int unsigned OffLen    = OffKnown + 1;
  localparam int unsigned OffTrunc  = OffLen + LenW;
  localparam int unsigned PackedW   = OffTrunc + 1;

  // One assembled instruction handed from front to back
  typedef struct packed {
    logic [WordW-1:0] first_word;
    logic [AddrW-1:0] addr;
    logic [ImmW-1:0]  imm_full;
    logic             use_full;
    logic [LenW-1:0]  len;
    logic             trunc;
  } rec_t;

  function automatic logic [CondW-1:0] cond_index(input logic [RegW-1:0] code);
    logic [CondW-1:0] idx;
    unique case (code)
      5'd0:    idx = 5'd0;
      5'd1:    idx = 5'd1;
      5'd2:    idx = 5'd2;
      5'd4:    idx = 5'd3;
      5'd5:    idx = 5'd4;
      5'd6:    idx = 5'd5;
      5'd8:    idx = 5'd6;
      5'd9:    idx = 5'd7;
      5'd10:   idx = 5'd8;
      5'd20:   idx = 5'd9;
      5'd21:   idx = 5'd10;
      5'd22:   idx = 5'd11;
      5'd24:   idx = 5'd12;
      5'd25:   idx = 5'd13;
      5'd26:   idx = 5'd14;
      5'd31:   idx = 5'd15;
      default: idx = COND_UNDEF;
    endcase
    return idx;
  endfunction

  function automatic logic op_known(input logic [OpW-1:0] op);
    logic k;
    unique case (op)
      6'd18, 6'd19, 6'd20, 6'd54, 6'd55, 6'd56, 6'd57: k = 1'b0;
      default: k = 1'b1;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/rsd_front.sv
// ----------------------------------------------------------------------------
// rsd_front: word intake and instruction assembly
// Tracks the byte address, gathers movei extension words and emits one
// record per complete (or cut short) instruction.
// ----------------------------------------------------------------------------
module rsd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsd_pkg::StartW-1:0]    cfg_wdata_i,
  input  logic                          word_valid_i,
  output logic                          word_ready_o,
  input  logic [rsd_pkg::WordW-1:0]     word_i,
  input  logic                          last_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output rsd_pkg::rec_t                 rec_o
);
  import rsd_pkg::*;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_HIGH = 2'd1,
    PEND_LOW  = 2'd2
  } pend_e;

  logic [StartW-1:0] start_q;
  logic [AddrW-1:0]  addr_q, addr_d, addr_eff;
  pend_e             pend_q, pend_d, pend_eff;
  logic [WordW-1:0]  first_q, first_d, low_q, low_d;
  logic              at_start_q, at_start_d;
  logic              accept, emit;

  assign word_ready_o = !q_full_i;
  assign accept       = word_valid_i && word_ready_o;
  assign push_o       = accept && emit;

  assign addr_eff = at_start_q ? {{(AddrW-StartW){1'b0}}, start_q} : addr_q;
  assign pend_eff = at_start_q ? PEND_NONE : pend_q;

  always_comb begin
    pend_d     = pend_eff;
    first_d    = first_q;
    low_d      = low_q;
    emit       = 1'b0;
    rec_o      = '0;
    unique case (pend_eff)
      PEND_LOW: begin
        low_d = word_i;
        if (last_i) begin
          emit  = 1'b1;
          rec_o = '{first_word: first_q, addr: addr_eff - AddrW'(2),
                    imm_full: {{(ImmW-WordW){1'b0}}, word_i}, use_full: 1'b1,
                    len: LenW'(2), trunc: 1'b1};
        end else begin
          pend_d = PEND_HIGH;
        end
      end
      PEND_HIGH: begin
        emit   = 1'b1;
        pend_d = PEND_NONE;
        rec_o  = '{first_word: first_q, addr: addr_eff - AddrW'(4),
                   imm_full: {word_i, low_q}, use_full: 1'b1,
                   len: LenW'(3), trunc: 1'b0};
      end
      default: begin
        pend_d = PEND_NONE;
        if (word_i[WordW-1 -: OpW] == OP_MOVEI) begin
          first_d = word_i;
          if (last_i) begin
            emit  = 1'b1;
            rec_o = '{first_word: word_i, addr: addr_eff, imm_full: '0,
                      use_full: 1'b1, len: LenW'(1), trunc: 1'b1};
          end else begin
            pend_d = PEND_LOW;
          end
        end else begin
          emit  = 1'b1;
          rec_o = '{first_word: word_i, addr: addr_eff, imm_full: '0,
                    use_full: 1'b0, len: LenW'(1), trunc: 1'b0};
        end
      end
    endcase
    // a program end clears the pending state (a movei cut short is still emitted) and rearms the start address
    if (last_i) pend_d = PEND_NONE;
    at_start_d = last_i;
    addr_d     = addr_eff + AddrW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      addr_q     <= '0;
      pend_q     <= PEND_NONE;
      at_start_q <= 1'b1;
      first_q    <= '0;
      low_q      <= '0;
    end else begin
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (accept) begin
        addr_q     <= addr_d;
        pend_q     <= pend_d;
        at_start_q <= at_start_d;
        first_q    <= first_d;
        low_q      <= low_d;
      end
    end
  end

endmodule

FILE: rtl/rsd_fifo.sv
// ----------------------------------------------------------------------------
// rsd_fifo: record queue between front and back
// Small synchronous queue; head entry is visible without a pop.
// ----------------------------------------------------------------------------
module rsd_fifo #(
  parameter int unsigned Depth = rsd_pkg::FifoDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsd_pkg::rec_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output rsd_pkg::rec_t head_o
);
  import rsd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/rsd_back.sv
// ----------------------------------------------------------------------------
// rsd_back: field decode and output register
// Slices the first word, adjusts immediates, works out the jr target and
// condition index, and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module rsd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  rsd_pkg::rec_t                 head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rsd_pkg::OutDataW-1:0]  out_data_o
);
  import rsd_pkg::*;

  logic [OpW-1:0]      op;
  logic [RegW-1:0]     rs, rd;
  logic [ImmW-1:0]     imm;
  logic [AddrW-1:0]    target;
  logic [CondW-1:0]    cond;
  logic [PackedW-1:0]  packed_d;
  logic [OutDataW-1:0] data_q;
  logic                valid_q;
  logic                load;

  assign op = head_i.first_word[WordW-1 -: OpW];
  assign rs = head_i.first_word[2*RegW-1 -: RegW];
  assign rd = head_i.first_word[RegW-1:0];

  always_comb begin
    imm    = {{(ImmW-RegW){1'b0}}, rs};
    target = '0;
    cond   = '0;
    if (head_i.use_full) begin
      imm = head_i.imm_full;
    end else if (op == OP_ADDQ || op == OP_ADDQT || op == OP_SUBQ || op == OP_SUBQT) begin
      if (rs == '0) imm = ImmW'(32);
    end else if (op == OP_SHLQ) begin
      imm = ImmW'(32) - {{(ImmW-RegW){1'b0}}, rs};
    end
    // jr: offset in words, sign extended from the 5-bit field
    if (op == OP_JR) begin
      target = head_i.addr + {{(AddrW-RegW-1){rs[RegW-1]}}, rs, 1'b0};
    end
    if (op == OP_JR || op == OP_JUMP) cond = cond_index(rd);
  end

  assign packed_d = {head_i.trunc, head_i.len, op_known(op), cond, target, imm,
                     rd, rs, op, head_i.addr};

  assign load        = !valid_q || out_ready_i;
  assign pop_o       = load && head_valid_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= {{(OutDataW-PackedW){1'b0}}, packed_d};
  end

endmodule

FILE: rtl/risc_instruction_stream_decoder.sv
// ----------------------------------------------------------------------------
// risc_instruction_stream_decoder: 16-bit RISC instruction stream decoder
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata = word, tlast = last_word
//   m_axis    out        m_axis_tvalid/tready       tdata = decoded instruction
//   cfg       in         cfg_we_i                   cfg_wdata_i = start_address
//
// One word is taken per cycle while the queue is not full; a result passes
// through a queue entry, then the output register, before it is offered.
// movei takes three words and gives one result; others give one per word.
// Reset clears the queue and the output valid and arms the start address.
// The queue lets words keep flowing while m_axis stalls, until it is full.
// ----------------------------------------------------------------------------
module risc_instruction_stream_decoder #(
  parameter int unsigned FifoDepth = rsd_pkg::FifoDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rsd_pkg::StartW-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rsd_pkg::WordW-1:0]    s_axis_tdata,  // word
  input  logic                         s_axis_tlast,  // last_word
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // instr_address, opcode, reg_src, reg_dst, immediate, jump_target,
  // condition, known, length_words, truncated, zero fill
  output logic [rsd_pkg::OutDataW-1:0] m_axis_tdata
);
  import rsd_pkg::*;

  rec_t front_rec, head_rec;
  logic push, q_full, head_valid, pop;

  rsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .word_valid_i (s_axis_tvalid),
    .word_ready_o (s_axis_tready),
    .word_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (front_rec)
  );

  rsd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_rec),
    .full_o      (q_full),
    .valid_o     (head_valid),
    .pop_i       (pop),
    .head_o      (head_rec)
  );

  rsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_rec),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule

FILE: rtl/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker: port-level checks for the instruction stream decoder
// Watches the result stream for held transactions and consistent fields.
// ----------------------------------------------------------------------------
module rsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [rsd_pkg::OutDataW-1:0] m_axis_tdata
);
  import rsd_pkg::*;

  logic [OpW-1:0]   op;
  logic [AddrW-1:0] target;
  logic [CondW-1:0] cond;
  logic [LenW-1:0]  len;
  logic             trunc;

  assign op     = m_axis_tdata[OffOp +: OpW];
  assign target = m_axis_tdata[OffTarget +: AddrW];
  assign cond   = m_axis_tdata[OffCond +: CondW];
  assign len    = m_axis_tdata[OffLen +: LenW];
  assign trunc  = m_axis_tdata[OffTrunc];

  // hold a stalled transaction
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && op != OP_JR |-> target == '0)
    else $error("jump target set for a non-jr opcode");

  a_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cond <= COND_UNDEF) &&
                      ((op == OP_JR || op == OP_JUMP) || cond == '0))
    else $error("condition index out of range");

  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && trunc |-> op == OP_MOVEI && (len == LenW'(1) || len == LenW'(2)))
    else $error("truncated flag on a complete instruction");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> len != '0 && ((op == OP_MOVEI) || len == LenW'(1)))
    else $error("bad instruction length");

endmodule

bind risc_instruction_stream_decoder rsd_checker u_rsd_checker (.*);
